// ===== src/jpbd_pkg.sv =====
package jpbd_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned PendW   = 3;

  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] ChLoA   = 8'h61;
  localparam logic [CharW-1:0] ChLoZ   = 8'h7A;
  localparam logic [CharW-1:0] ChDig0  = 8'h30;
  localparam logic [CharW-1:0] ChDig9  = 8'h39;
  localparam logic [CharW-1:0] ChDash  = 8'h2D;
  localparam logic [CharW-1:0] ChUnder = 8'h5F;

  localparam logic [CharW-1:0] LowerBase = 8'd26;
  localparam logic [CharW-1:0] DigitBase = 8'd52;
  localparam logic [SextetW-1:0] DashVal  = 6'd62;
  localparam logic [SextetW-1:0] UnderVal = 6'd63;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_NO_FIRST_DOT  = 2'd1,
    ST_NO_SECOND_DOT = 2'd2
  } status_e;

  typedef struct packed {
    logic               valid;
    logic [SextetW-1:0] value;
  } sextet_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       token_end;
    status_e    status;
  } result_t;

  function automatic sextet_t sextet_of(input logic [CharW-1:0] ch);
    sextet_t s;
    logic [CharW-1:0] v;
    s = '0;
    v = '0;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      v = ch - ChUpA;
      s.valid = 1'b1;
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      v = ch - ChLoA + LowerBase;
      s.valid = 1'b1;
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      v = ch - ChDig0 + DigitBase;
      s.valid = 1'b1;
    end else if (ch == ChDash) begin
      v = {2'b00, DashVal};
      s.valid = 1'b1;
    end else if (ch == ChUnder) begin
      v = {2'b00, UnderVal};
      s.valid = 1'b1;
    end
    s.value = v[SextetW-1:0];
    return s;
  endfunction

endpackage

// ===== src/jpbd_in_stage.sv =====
module jpbd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  jpbd_pkg::in_item_t item_i,
  input  logic               drain_i,
  output logic               valid_o,
  output jpbd_pkg::in_item_t item_o
);
  import jpbd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign ready_o = !valid_q || drain_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (drain_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== src/jpbd_decode.sv =====
module jpbd_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  jpbd_pkg::in_item_t item_i,
  output logic               emit_o,
  output jpbd_pkg::result_t  result_o
);
  import jpbd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEAD    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_TAIL    = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [SextetW-1:0]  acc_q, acc_d;
  logic [PendW-1:0]    pend_q, pend_d;
  sextet_t             sx;
  logic [PendW-1:0]    p_eff;
  logic [3:0]          total;
  logic [PendW-1:0]    rest;
  logic [11:0]         comb_bits;
  logic [11:0]         keep_mask;
  result_t             res;

  assign sx        = sextet_of(item_i.char_code);
  assign p_eff     = (pend_q > 3'd6) ? 3'd6 : pend_q;
  assign total     = {1'b0, p_eff} + 4'd6;
  assign rest      = 3'(total - 4'd8);
  assign comb_bits = {acc_q, sx.value};
  assign keep_mask = (12'd1 << rest) - 12'd1;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    res     = '0;
    if (fire_i) begin
      unique case (phase_q)
        PH_HEAD: begin
          if (item_i.char_code == ChDot) begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (item_i.char_code == ChDot) begin
            phase_d = PH_TAIL;
          end else if (sx.valid) begin
            if (total >= 4'd8) begin
              res.data_byte  = 8'(comb_bits >> rest);
              res.byte_valid = 1'b1;
              acc_d          = 6'(comb_bits & keep_mask);
              pend_d         = rest;
            end else begin
              acc_d  = sx.value;
              pend_d = total[PendW-1:0];
            end
          end
        end
        default: begin
        end
      endcase
      if (item_i.last_char) begin
        res.token_end = 1'b1;
        unique case (phase_d)
          PH_HEAD:    res.status = ST_NO_FIRST_DOT;
          PH_PAYLOAD: res.status = ST_NO_SECOND_DOT;
          default:    res.status = ST_OK;
        endcase
        phase_d = PH_HEAD;
        acc_d   = '0;
        pend_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      acc_q   <= '0;
      pend_q  <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
    end
  end

  assign emit_o   = fire_i && (res.byte_valid || res.token_end);
  assign result_o = res;

  a_pend_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q[0] && pend_q != 3'd7)
    else $error("pending bit count left the even range");

  a_clear_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last_char |=> phase_q == PH_HEAD && pend_q == '0 && acc_q == '0)
    else $error("state not cleared after token end");

  a_byte_in_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res.byte_valid |-> phase_q == PH_PAYLOAD && pend_q != '0)
    else $error("byte emitted outside payload or without pending bits");

  a_acc_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 3'd6 |-> (acc_q >> pend_q) == '0)
    else $error("accumulator holds bits above the pending count");

endmodule

// ===== src/jpbd_out_stage.sv =====
module jpbd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jpbd_pkg::result_t result_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output jpbd_pkg::result_t result_o
);
  import jpbd_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

// ===== src/jwt_payload_base64url_decoder_unit.sv =====
// Base64url payload decoder for dot-separated tokens.
// Slave stream: one token character per transaction in s_axis_tdata,
// s_axis_tlast set on the token's final character.
// Master stream: m_axis_tdata carries a decoded payload byte; m_axis_tuser
// bit 0 flags that the byte is valid, bits 2:1 give the status on the
// final transaction (0 ok, 1 no first dot, 2 no second dot); m_axis_tlast
// marks the token end. Only characters between the first and second dot
// are decoded; a character that yields no byte and is not final produces
// no master transaction. Drop the bytes of a token whose status is not ok.
// A character is held in the input register, then decoded into the result
// register that drives m_axis_tvalid. Throughput: one character per cycle
// while the result register is free, set by the single decode step.
// Reset clears the token state and both stage valids; the first character
// after reset starts a new token.
// When the master side stalls, the result register holds and s_axis_tready
// drops once the input register is also occupied.
module jwt_payload_base64url_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_code
  input  logic       s_axis_tlast,  // last_char
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] data_byte
  output logic [2:0] m_axis_tuser,  // [0] byte_valid, [2:1] status
  output logic       m_axis_tlast   // token_end
);
  import jpbd_pkg::*;

  in_item_t in_item, stage_item;
  logic     stage_valid;
  logic     out_free;
  logic     fire;
  logic     emit;
  result_t  dec_result, out_result;

  assign in_item.char_code = s_axis_tdata;
  assign in_item.last_char = s_axis_tlast;
  assign fire = stage_valid && out_free;

  jpbd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .drain_i (out_free),
    .valid_o (stage_valid),
    .item_o  (stage_item)
  );

  jpbd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_item),
    .emit_o   (emit),
    .result_o (dec_result)
  );

  jpbd_out_stage u_out_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (dec_result),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (out_result)
  );

  assign m_axis_tdata = out_result.data_byte;
  assign m_axis_tuser = {out_result.status, out_result.byte_valid};
  assign m_axis_tlast = out_result.token_end;

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[2:1] == ST_OK && m_axis_tuser[0])
    else $error("result without token end carries no byte or a status");

  a_no_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
    else $error("empty result presented");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser[2:1] != 2'd3)
    else $error("status code out of range");

endmodule

// ===== sim/jpbd_stream_checker.sv =====
module jpbd_stream_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,   // [7:0] char_code
  input  logic       s_tlast_i,   // last_char
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,   // [7:0] data_byte
  input  logic [2:0] m_tuser_i,   // [0] byte_valid, [2:1] status
  input  logic       m_tlast_i,   // token_end
  output int         fail_count_o,
  output int         awaited_o,
  output int         chars_o,
  output int         tokens_o,
  output int         good_tokens_o,
  output int         bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import jpbd_pkg::*;

  localparam logic [1:0] PhHeader  = 2'd0;
  localparam logic [1:0] PhPayload = 2'd1;
  localparam logic [1:0] PhTrailer = 2'd2;

  logic [1:0] seg_phase;
  logic [5:0] carry_bits;
  logic [2:0] carry_count;
  result_t    awaited_results[$];

  function automatic logic [6:0] sextet_lookup(input logic [7:0] ch);
    logic [7:0] val;
    logic       hit;
    hit = 1'b1;
    val = '0;
    if (ch >= ChUpA && ch <= ChUpZ) val = ch - ChUpA;
    else if (ch >= ChLoA && ch <= ChLoZ) val = (ch - ChLoA) + LowerBase;
    else if (ch >= ChDig0 && ch <= ChDig9) val = (ch - ChDig0) + DigitBase;
    else if (ch == ChDash) val = {2'b00, DashVal};
    else if (ch == ChUnder) val = {2'b00, UnderVal};
    else hit = 1'b0;
    return {hit, val[5:0]};
  endfunction

  task automatic clear_token();
    seg_phase   = PhHeader;
    carry_bits  = '0;
    carry_count = '0;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic last);
    logic [6:0]  lookup;
    logic [11:0] joined;
    logic [11:0] shifted;
    logic [11:0] kept;
    logic [3:0]  total;
    logic [3:0]  spare;
    logic        emitted;
    result_t     res;
    emitted = 1'b0;
    res = '0;
    res.status = ST_OK;
    case (seg_phase)
      PhHeader: begin
        if (ch == ChDot) seg_phase = PhPayload;
      end
      PhPayload: begin
        if (ch == ChDot) begin
          seg_phase = PhTrailer;
        end else begin
          lookup = sextet_lookup(ch);
          if (lookup[6]) begin
            joined = {carry_bits, lookup[5:0]};
            total = ((carry_count > 3'd6) ? 4'd6 : {1'b0, carry_count}) + 4'd6;
            if (total >= 4'd8) begin
              spare = total - 4'd8;
              shifted = joined >> spare;
              kept = joined & ((12'd1 << spare) - 12'd1);
              res.data_byte = shifted[7:0];
              emitted = 1'b1;
              carry_bits = kept[5:0];
              carry_count = spare[2:0];
            end else begin
              carry_bits = joined[5:0];
              carry_count = total[2:0];
            end
          end
        end
      end
      default: ;
    endcase
    if (emitted || last) begin
      res.byte_valid = emitted;
      res.token_end = last;
      if (last) begin
        if (seg_phase == PhHeader) res.status = ST_NO_FIRST_DOT;
        else if (seg_phase == PhPayload) res.status = ST_NO_SECOND_DOT;
        else res.status = ST_OK;
        clear_token();
      end
      awaited_results = {awaited_results, res};
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_token();
      awaited_results.delete();
      fail_count_o   = 0;
      awaited_o     <= 0;
      chars_o       <= 0;
      tokens_o      <= 0;
      good_tokens_o <= 0;
      bytes_o       <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %0h/%0h/%0b",
                   $time, m_tdata_i, m_tuser_i, m_tlast_i);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("data_byte", want.data_byte, m_tdata_i);
          check_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, m_tuser_i[0]});
          check_field("token_end", {7'd0, want.token_end}, {7'd0, m_tlast_i});
          check_field("status", {6'd0, want.status}, {6'd0, m_tuser_i[2:1]});
        end
        if (m_tuser_i[0]) bytes_o <= bytes_o + 1;
        if (m_tlast_i) begin
          tokens_o <= tokens_o + 1;
          if (m_tuser_i[2:1] == ST_OK) good_tokens_o <= good_tokens_o + 1;
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        decode_char(s_tdata_i, s_tlast_i);
        chars_o <= chars_o + 1;
      end
      awaited_o <= awaited_results.size();
    end
  end

endmodule

// ===== sim/jwt_payload_base64url_decoder_unit_tb.sv =====
module jwt_payload_base64url_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import jpbd_pkg::*;

  localparam int TargetChars = 850;
  localparam int IdlePct     = 38;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam logic [7:0] ChPad = 8'h3D;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;
  logic       m_axis_tlast;

  int fail_count;
  int awaited;
  int chars_seen;
  int tokens_seen;
  int good_tokens;
  int bytes_seen;
  int quiet_cycles = 0;
  int sent = 0;
  bit calm = 1'b0;

  logic [7:0] token_chars[$];

  // {last_char, char_code}
  logic [8:0] opening_run[22] = '{
    {1'b0, 8'h00}, {1'b0, ChDot}, {1'b0, "A"}, {1'b0, "Z"}, {1'b0, "a"}, {1'b0, "z"},
    {1'b0, "0"}, {1'b0, "9"}, {1'b0, ChDash}, {1'b0, ChUnder}, {1'b0, ChPad},
    {1'b0, 8'hFF}, {1'b0, ChDot}, {1'b1, 8'hFF},
    {1'b0, ChDot}, {1'b0, "Q"}, {1'b0, "U"}, {1'b1, "J"},
    {1'b0, "a"}, {1'b0, "b"}, {1'b1, "c"},
    {1'b1, ChDot}
  };

  always #1 clk_i = ~clk_i;

  jwt_payload_base64url_decoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  jpbd_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tlast_i     (s_axis_tlast),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .m_tuser_i     (m_axis_tuser),
    .m_tlast_i     (m_axis_tlast),
    .fail_count_o  (fail_count),
    .awaited_o     (awaited),
    .chars_o       (chars_seen),
    .tokens_o      (tokens_seen),
    .good_tokens_o (good_tokens),
    .bytes_o       (bytes_seen)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, awaited);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] pick_b64();
    int v;
    v = $urandom_range(63);
    if (v < 26) return ChUpA + 8'(v);
    if (v < 52) return ChLoA + 8'(v - 26);
    if (v < 62) return ChDig0 + 8'(v - 52);
    if (v == 62) return ChDash;
    return ChUnder;
  endfunction

  function automatic logic [7:0] pick_non_dot();
    logic [7:0] ch;
    ch = 8'($urandom_range(255));
    while (ch == ChDot) ch = 8'($urandom_range(255));
    return ch;
  endfunction

  function automatic logic [7:0] pick_payload_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return pick_b64();
    if (roll < 90) return ChPad;
    return pick_non_dot();
  endfunction

  task automatic append_char(input logic [7:0] ch);
    token_chars = {token_chars, ch};
  endtask

  task automatic build_token();
    int roll;
    int len;
    token_chars.delete();
    if ($urandom_range(99) < 80) begin
      len = $urandom_range(6);
      repeat (len) append_char(pick_non_dot());
      append_char(ChDot);
      len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(16);
      repeat (len) append_char(pick_payload_char());
      append_char(ChDot);
      len = $urandom_range(6);
      repeat (len) begin
        if ($urandom_range(9) == 0) append_char(ChDot);
        else append_char(8'($urandom_range(255)));
      end
    end else begin
      len = $urandom_range(1, 12);
      repeat (len) begin
        roll = $urandom_range(99);
        if (roll < 20) append_char(ChDot);
        else if (roll < 70) append_char(pick_b64());
        else append_char(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening_run[i]) send_char(opening_run[i][7:0], opening_run[i][8]);
    while (sent < TargetChars) begin
      calm = (sent >= 350 && sent < 500);
      build_token();
      foreach (token_chars[i]) send_char(token_chars[i], i == token_chars.size() - 1);
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("run covered %0d characters in %0d tokens, %0d of them well formed,",
             chars_seen, tokens_seen, good_tokens);
    $display("with %0d decoded bytes checked under random idling on both streams", bytes_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== jwt_payload_base64url_decoder_unit.f =====
src/jpbd_pkg.sv
src/jpbd_in_stage.sv
src/jpbd_decode.sv
src/jpbd_out_stage.sv
src/jwt_payload_base64url_decoder_unit.sv
sim/jpbd_stream_checker.sv
sim/jwt_payload_base64url_decoder_unit_tb.sv
